### design/c8080_pkg.sv
// ----------------------------------------------------------------------------
// c8080_pkg: shared types for the 8080 execute core
// Item kinds, controller states and the command/status structs.
// ----------------------------------------------------------------------------
package c8080_pkg;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_EXEC  = 2'd1,
		KIND_READ  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH_OP,
		ST_FETCH_B1,
		ST_FETCH_B2,
		ST_WAIT_B2,
		ST_OPER_RD,
		ST_OPER_RD2,
		ST_OPER_LAT,
		ST_EXEC,
		ST_OPER_WR2,
		ST_MEMRD_WAIT,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		MA_ITEM,
		MA_PC,
		MA_PC1,
		MA_PC2,
		MA_OPER,
		MA_OPER1
	} maddr_t;

	typedef struct packed {
		logic   start;
		logic   mem_en;
		logic   mem_we;
		maddr_t maddr;
		logic   wdata_hi;
		logic   lat_op;
		logic   lat_b1;
		logic   lat_b2;
		logic   lat_rd;
		logic   lat_rd2;
		logic   do_exec;
		logic   do_write;
		logic   set_out;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  bad;
		logic  need_b1;
		logic  need_b2;
		logic  need_rd;
		logic  need_rd2;
		logic  need_wr;
		logic  need_wr2;
	} stat_t;

endpackage

### design/cpu8080_instruction_execute_core.sv
// ----------------------------------------------------------------------------
// cpu8080_instruction_execute_core: 8080 executor for opcodes 00h-8Fh
// A word either writes a memory byte, reads one, runs one instruction
// fetched at PC from the internal single-port memory, or does nothing. Every
// word gives one result word with the full register file. An instruction
// steps through the single memory port: three fetch reads, then for memory
// operands up to two reads and a state to latch the operand, then up to two
// writes. The next word can be taken at the earliest in the cycle the result
// shows, unless the output stalls. The memory is not cleared at reset.
// ----------------------------------------------------------------------------
module cpu8080_instruction_execute_core #(
	parameter int MEM_ADDR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [15:0] address,
	input  logic [7:0]  data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic [15:0] prog_counter,
	output logic [15:0] stack_ptr,
	output logic [7:0]  accum,
	output logic [15:0] pair_bc,
	output logic [15:0] pair_de,
	output logic [15:0] pair_hl,
	output logic [3:0]  flag_bits,
	output logic        bad_opcode
);
	import c8080_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	c8080_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	c8080_datapath #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.kind         (kind),
		.address      (address),
		.data         (data),
		.read_data    (read_data),
		.prog_counter (prog_counter),
		.stack_ptr    (stack_ptr),
		.accum        (accum),
		.pair_bc      (pair_bc),
		.pair_de      (pair_de),
		.pair_hl      (pair_hl),
		.flag_bits    (flag_bits),
		.bad_opcode   (bad_opcode)
	);
endmodule

### design/c8080_ram.sv
// ----------------------------------------------------------------------------
// c8080_ram: generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module c8080_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) mem_q[addr] <= wdata;
			else rdata <= mem_q[addr];
		end
	end
endmodule

### design/c8080_datapath.sv
// ----------------------------------------------------------------------------
// c8080_datapath: registers, memory and ALU of the 8080 execute core
// Holds the architectural state, decodes the fetched opcode and applies it.
// ----------------------------------------------------------------------------
module c8080_datapath #(
	parameter int MEM_ADDR_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  c8080_pkg::cmd_t   cmd,
	output c8080_pkg::stat_t  stat,
	input  logic [1:0]        kind,
	input  logic [15:0]       address,
	input  logic [7:0]        data,
	output logic [7:0]        read_data,
	output logic [15:0]       prog_counter,
	output logic [15:0]       stack_ptr,
	output logic [7:0]        accum,
	output logic [15:0]       pair_bc,
	output logic [15:0]       pair_de,
	output logic [15:0]       pair_hl,
	output logic [3:0]        flag_bits,
	output logic              bad_opcode
);
	import c8080_pkg::*;

	localparam int Depth = 1 << MEM_ADDR_BITS;

	logic [15:0] pc_q, sp_q, bc_q, de_q, hl_q;
	logic [7:0]  a_q;
	logic [3:0]  f_q;
	logic [1:0]  kind_q;
	logic [15:0] addr_q;
	logic [7:0]  data_q;
	logic [7:0]  op_q, b1_q, b2_q, rd_q, rd2_q;
	logic [7:0]  mem_rdata, mem_wdata;
	logic [15:0] mem_addr16, oper_addr;

	logic [15:0] imm;
	logic [1:0]  rp;
	logic [2:0]  ddd, sss;

	assign imm = {b2_q, b1_q};
	assign rp  = op_q[5:4];
	assign ddd = op_q[5:3];
	assign sss = op_q[2:0];

	function automatic logic [15:0] get_rp(input logic [1:0] p, input logic [15:0] bc,
		input logic [15:0] de, input logic [15:0] hl, input logic [15:0] sp);
		case (p)
			2'd0: get_rp = bc;
			2'd1: get_rp = de;
			2'd2: get_rp = hl;
			default: get_rp = sp;
		endcase
	endfunction

	function automatic logic [7:0] get_r(input logic [2:0] c, input logic [15:0] bc,
		input logic [15:0] de, input logic [15:0] hl, input logic [7:0] a,
		input logic [7:0] m);
		case (c)
			3'd0: get_r = bc[15:8];
			3'd1: get_r = bc[7:0];
			3'd2: get_r = de[15:8];
			3'd3: get_r = de[7:0];
			3'd4: get_r = hl[15:8];
			3'd5: get_r = hl[7:0];
			3'd6: get_r = m;
			default: get_r = a;
		endcase
	endfunction

	// Status decoding from the latched opcode.
	always_comb begin
		stat = '0;
		stat.kind = kind_t'(kind_q);
		stat.bad  = op_q > 8'h8f;
		if (!stat.bad) begin
			if (op_q >= 8'h80) begin
				stat.need_rd = sss == 3'd6;
			end else if (op_q >= 8'h40) begin
				stat.need_rd = (sss == 3'd6) && (op_q != 8'h76);
				stat.need_wr = (ddd == 3'd6) && (op_q != 8'h76);
			end else begin
				unique case (sss)
					3'd1: begin
						stat.need_b1 = !op_q[3];
						stat.need_b2 = !op_q[3];
					end
					3'd2: begin
						if (rp[1]) begin
							stat.need_b1 = 1'b1;
							stat.need_b2 = 1'b1;
						end
						stat.need_rd  = op_q[3];
						stat.need_rd2 = op_q[3] && rp == 2'd2;
						stat.need_wr  = !op_q[3];
						stat.need_wr2 = !op_q[3] && rp == 2'd2;
					end
					3'd4, 3'd5: begin
						stat.need_rd = ddd == 3'd6;
						stat.need_wr = ddd == 3'd6;
					end
					3'd6: begin
						stat.need_b1 = 1'b1;
						stat.need_wr = ddd == 3'd6;
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		if (op_q < 8'h40 && sss == 3'd2)
			oper_addr = rp[1] ? imm : get_rp(rp, bc_q, de_q, hl_q, sp_q);
		else
			oper_addr = hl_q;
	end

	always_comb begin
		case (cmd.maddr)
			MA_ITEM:  mem_addr16 = addr_q;
			MA_PC:    mem_addr16 = pc_q;
			MA_PC1:   mem_addr16 = pc_q + 16'd1;
			MA_PC2:   mem_addr16 = pc_q + 16'd2;
			MA_OPER:  mem_addr16 = oper_addr;
			default:  mem_addr16 = oper_addr + 16'd1;
		endcase
	end

	// Execute results, computed against the latched operands.
	logic [15:0] n_pc, n_sp, n_bc, n_de, n_hl;
	logic [7:0]  n_a, wr_val, wr2_val, src, v8;
	logic [3:0]  n_f;
	logic [8:0]  sum9;
	logic [16:0] sum17;
	logic        setz;

	function automatic logic [3:0] szp(input logic [7:0] v, input logic cy);
		szp = {v[7], v == 8'h00, ~^v, cy};
	endfunction

	always_comb begin
		n_pc = pc_q + 16'd1;
		n_sp = sp_q;
		n_bc = bc_q;
		n_de = de_q;
		n_hl = hl_q;
		n_a  = a_q;
		n_f  = f_q;
		wr_val  = a_q;
		wr2_val = hl_q[15:8];
		setz = 1'b0;
		v8 = 8'h00;
		src = get_r(sss, bc_q, de_q, hl_q, a_q, rd_q);
		sum9 = {1'b0, a_q} + {1'b0, src} + {8'h00, op_q[3] & f_q[0]};
		sum17 = {1'b0, hl_q} + {1'b0, get_rp(rp, bc_q, de_q, hl_q, sp_q)};
		if (op_q >= 8'h80) begin
			n_a = sum9[7:0];
			n_f = szp(sum9[7:0], sum9[8]);
		end else if (op_q >= 8'h40) begin
			v8 = src;
			setz = op_q != 8'h76;
			wr_val = src;
		end else begin
			unique case (sss)
				3'd1: begin
					if (op_q[3]) begin
						n_hl = sum17[15:0];
						n_f[0] = sum17[16];
					end else begin
						n_pc = pc_q + 16'd3;
						unique case (rp)
							2'd0: n_bc = imm;
							2'd1: n_de = imm;
							2'd2: n_hl = imm;
							default: n_sp = imm;
						endcase
					end
				end
				3'd2: begin
					if (rp[1]) n_pc = pc_q + 16'd3;
					if (rp == 2'd2) begin
						wr_val = hl_q[7:0];
						if (op_q[3]) n_hl = {rd2_q, rd_q};
					end else if (op_q[3]) begin
						n_a = rd_q;
					end
				end
				3'd3: begin
					unique case (rp)
						2'd0: n_bc = op_q[3] ? bc_q - 16'd1 : bc_q + 16'd1;
						2'd1: n_de = op_q[3] ? de_q - 16'd1 : de_q + 16'd1;
						2'd2: n_hl = op_q[3] ? hl_q - 16'd1 : hl_q + 16'd1;
						default: n_sp = op_q[3] ? sp_q - 16'd1 : sp_q + 16'd1;
					endcase
				end
				3'd4, 3'd5: begin
					v8 = sss[0] ? get_r(ddd, bc_q, de_q, hl_q, a_q, rd_q) - 8'd1
						: get_r(ddd, bc_q, de_q, hl_q, a_q, rd_q) + 8'd1;
					setz = 1'b1;
					n_f = szp(v8, f_q[0]);
					wr_val = v8;
				end
				3'd6: begin
					n_pc = pc_q + 16'd2;
					v8 = b1_q;
					setz = 1'b1;
					wr_val = b1_q;
				end
				3'd7: begin
					unique case (ddd)
						3'd0: begin n_a = {a_q[6:0], a_q[7]}; n_f[0] = a_q[7]; end
						3'd1: begin n_a = {a_q[0], a_q[7:1]}; n_f[0] = a_q[0]; end
						3'd2: begin n_a = {a_q[6:0], f_q[0]}; n_f[0] = a_q[7]; end
						3'd3: begin n_a = {f_q[0], a_q[7:1]}; n_f[0] = a_q[0]; end
						3'd5: n_a = ~a_q;
						3'd6: n_f[0] = 1'b1;
						3'd7: n_f[0] = ~f_q[0];
						default: ;
					endcase
				end
				default: ;
			endcase
		end
		if (setz && ddd != 3'd6) begin
			unique case (ddd)
				3'd0: n_bc[15:8] = v8;
				3'd1: n_bc[7:0]  = v8;
				3'd2: n_de[15:8] = v8;
				3'd3: n_de[7:0]  = v8;
				3'd4: n_hl[15:8] = v8;
				3'd5: n_hl[7:0]  = v8;
				default: n_a = v8;
			endcase
		end
	end

	assign mem_wdata = (cmd.maddr == MA_ITEM) ? data_q : (cmd.wdata_hi ? wr2_val : wr_val);

	c8080_ram #(.WIDTH(8), .DEPTH(Depth)) u_ram (
		.clk   (clk),
		.en    (cmd.mem_en),
		.we    (cmd.mem_we),
		.addr  (mem_addr16[MEM_ADDR_BITS-1:0]),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			kind_q <= kind;
			addr_q <= address;
			data_q <= data;
		end
		if (cmd.lat_op)  op_q  <= mem_rdata;
		if (cmd.lat_b1)  b1_q  <= mem_rdata;
		if (cmd.lat_b2)  b2_q  <= mem_rdata;
		if (cmd.lat_rd)  rd_q  <= mem_rdata;
		if (cmd.lat_rd2) rd2_q <= mem_rdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0; sp_q <= '0; bc_q <= '0; de_q <= '0; hl_q <= '0;
			a_q <= '0; f_q <= '0;
			read_data <= '0; bad_opcode <= 1'b0;
		end else begin
			if (cmd.do_exec) begin
				pc_q <= n_pc; sp_q <= n_sp; bc_q <= n_bc; de_q <= n_de; hl_q <= n_hl;
				a_q <= n_a; f_q <= n_f;
			end
			if (cmd.set_out) begin
				read_data  <= (kind_q == KIND_READ) ? mem_rdata : 8'h00;
				bad_opcode <= (kind_q == KIND_EXEC) && stat.bad;
			end
		end
	end

	assign prog_counter = pc_q;
	assign stack_ptr    = sp_q;
	assign accum        = a_q;
	assign pair_bc      = bc_q;
	assign pair_de      = de_q;
	assign pair_hl      = hl_q;
	assign flag_bits    = f_q;
endmodule

### design/c8080_ctrl.sv
// ----------------------------------------------------------------------------
// c8080_ctrl: sequencer of the 8080 execute core
// Steps each word through fetch, operand access, execute and delivery.
// ----------------------------------------------------------------------------
module c8080_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  c8080_pkg::stat_t stat,
	output c8080_pkg::cmd_t  cmd
);
	import c8080_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign out_valid = out_valid_q;
	assign in_stall  = state_q != ST_IDLE || (out_valid_q && out_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid && !in_stall) state_d = ST_FETCH_OP;
			ST_FETCH_OP: begin
				unique case (stat.kind)
					KIND_EXEC:  state_d = ST_FETCH_B1;
					KIND_WRITE: state_d = ST_DONE;
					KIND_READ:  state_d = ST_MEMRD_WAIT;
					default:    state_d = ST_DONE;
				endcase
			end
			ST_MEMRD_WAIT: state_d = ST_DONE;
			ST_FETCH_B1:   state_d = ST_FETCH_B2;
			ST_FETCH_B2:   state_d = ST_WAIT_B2;
			ST_WAIT_B2:    state_d = stat.bad ? ST_DONE
				: (stat.need_rd ? ST_OPER_RD : ST_EXEC);
			ST_OPER_RD:    state_d = stat.need_rd2 ? ST_OPER_RD2 : ST_OPER_LAT;
			ST_OPER_RD2:   state_d = ST_OPER_LAT;
			ST_OPER_LAT:   state_d = ST_EXEC;
			ST_EXEC:       state_d = stat.need_wr2 ? ST_OPER_WR2 : ST_DONE;
			ST_OPER_WR2:   state_d = ST_DONE;
			ST_DONE:       state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.maddr = MA_ITEM;
		unique case (state_q)
			ST_IDLE: cmd.start = in_valid && !in_stall;
			ST_FETCH_OP: begin
				cmd.mem_en = stat.kind != KIND_NONE;
				cmd.mem_we = stat.kind == KIND_WRITE;
				cmd.maddr  = (stat.kind == KIND_EXEC) ? MA_PC : MA_ITEM;
			end
			ST_MEMRD_WAIT: ;
			ST_FETCH_B1: begin
				cmd.mem_en = 1'b1;
				cmd.maddr  = MA_PC1;
				cmd.lat_op = 1'b1;
			end
			ST_FETCH_B2: begin
				cmd.mem_en = 1'b1;
				cmd.maddr  = MA_PC2;
				cmd.lat_b1 = 1'b1;
			end
			ST_WAIT_B2: begin
				cmd.lat_b2 = 1'b1;
			end
			ST_OPER_RD: begin
				cmd.mem_en = 1'b1;
				cmd.maddr  = MA_OPER;
			end
			ST_OPER_RD2: begin
				cmd.mem_en = 1'b1;
				cmd.maddr  = MA_OPER1;
				cmd.lat_rd = 1'b1;
			end
			ST_OPER_LAT: begin
				if (stat.need_rd2) cmd.lat_rd2 = 1'b1;
				else cmd.lat_rd = 1'b1;
			end
			ST_EXEC: begin
				cmd.do_exec = 1'b1;
				cmd.mem_en  = stat.need_wr;
				cmd.mem_we  = stat.need_wr;
				cmd.maddr   = MA_OPER;
			end
			ST_OPER_WR2: begin
				cmd.mem_en   = 1'b1;
				cmd.mem_we   = 1'b1;
				cmd.maddr    = MA_OPER1;
				cmd.wdata_hi = 1'b1;
			end
			ST_DONE: cmd.set_out = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end
endmodule

### verif/cpu8080_instruction_execute_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8080_instruction_execute_core_tb: self-checking bench for the 8080 core
// Loads small programs through memory write words, runs them one instruction
// at a time and compares every result word with a software model of the
// register file and memory. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module cpu8080_instruction_execute_core_tb;
	import c8080_pkg::*;

	localparam logic [7:0] OP_HLT       = 8'h76;
	localparam logic [7:0] OP_LAST_IMPL = 8'h8f;
	localparam int         ITEM_COUNT   = 1750;

	typedef struct packed {
		logic [7:0]  rdata;
		logic [15:0] pc;
		logic [15:0] sp;
		logic [7:0]  acc;
		logic [15:0] bc;
		logic [15:0] de;
		logic [15:0] hl;
		logic [3:0]  flags;
		logic        bad;
	} cpu_view_t;

	class exec_scoreboard;
		logic [7:0]  mem [0:65535];
		bit          written [0:65535];
		logic [15:0] pc, sp;
		logic [7:0]  acc;
		logic [7:0]  gp [0:5];
		logic [3:0]  fl;
		cpu_view_t   pending [$];
		int          errors;

		function new();
			pc = 0;
			sp = 0;
			acc = 0;
			fl = 0;
			errors = 0;
			foreach (gp[i]) gp[i] = 0;
		endfunction

		function void put_byte(logic [15:0] a, logic [7:0] v);
			mem[a] = v;
			written[a] = 1;
		endfunction

		function logic [15:0] pair_get(int p);
			if (p == 3) return sp;
			return {gp[2 * p], gp[2 * p + 1]};
		endfunction

		function void pair_set(int p, logic [15:0] v);
			if (p == 3) sp = v;
			else begin
				gp[2 * p] = v[15:8];
				gp[2 * p + 1] = v[7:0];
			end
		endfunction

		function logic [7:0] reg_get(int c);
			if (c == 7) return acc;
			if (c == 6) return mem[pair_get(2)];
			return gp[c];
		endfunction

		function void reg_set(int c, logic [7:0] v);
			if (c == 7) acc = v;
			else if (c == 6) put_byte(pair_get(2), v);
			else gp[c] = v;
		endfunction

		function void set_szp(logic [7:0] v);
			fl[3:1] = {v[7], v == 8'd0, ~^v};
		endfunction

		function bit run_instr();
			logic [7:0]  op, b1, b2, v, a0;
			logic [15:0] imm;
			logic [16:0] t;
			logic [8:0]  s;
			int          p, dd;
			op = mem[pc];
			b1 = mem[pc + 16'd1];
			b2 = mem[pc + 16'd2];
			imm = {b2, b1};
			p = op[5:4];
			dd = op[5:3];
			a0 = acc;
			if (op > OP_LAST_IMPL) return 1;
			pc = pc + 16'd1;
			if (op[7]) begin
				s = {1'b0, acc} + {1'b0, reg_get(op[2:0])} + {8'd0, op[3] & fl[0]};
				acc = s[7:0];
				fl[0] = s[8];
				set_szp(acc);
				return 0;
			end
			if (op[6]) begin
				if (op != OP_HLT) reg_set(dd, reg_get(op[2:0]));
				return 0;
			end
			case (op[2:0])
				3'd1: begin
					if (op[3]) begin
						t = {1'b0, pair_get(2)} + {1'b0, pair_get(p)};
						pair_set(2, t[15:0]);
						fl[0] = t[16];
					end else begin
						pair_set(p, imm);
						pc = pc + 16'd2;
					end
				end
				3'd2: begin
					if (p < 2) begin
						if (op[3]) acc = mem[pair_get(p)];
						else put_byte(pair_get(p), acc);
					end else begin
						pc = pc + 16'd2;
						if (p == 2) begin
							if (op[3]) begin
								gp[5] = mem[imm];
								gp[4] = mem[imm + 16'd1];
							end else begin
								put_byte(imm, gp[5]);
								put_byte(imm + 16'd1, gp[4]);
							end
						end else begin
							if (op[3]) acc = mem[imm];
							else put_byte(imm, acc);
						end
					end
				end
				3'd3: pair_set(p, op[3] ? pair_get(p) - 16'd1 : pair_get(p) + 16'd1);
				3'd4: begin
					v = reg_get(dd) + 8'd1;
					reg_set(dd, v);
					set_szp(v);
				end
				3'd5: begin
					v = reg_get(dd) - 8'd1;
					reg_set(dd, v);
					set_szp(v);
				end
				3'd6: begin
					reg_set(dd, b1);
					pc = pc + 16'd1;
				end
				3'd7: begin
					case (dd)
						0: begin acc = {a0[6:0], a0[7]}; fl[0] = a0[7]; end
						1: begin acc = {a0[0], a0[7:1]}; fl[0] = a0[0]; end
						2: begin acc = {a0[6:0], fl[0]}; fl[0] = a0[7]; end
						3: begin acc = {fl[0], a0[7:1]}; fl[0] = a0[0]; end
						5: acc = ~a0;
						6: fl[0] = 1'b1;
						7: fl[0] = ~fl[0];
						default: ;
					endcase
				end
				default: ;
			endcase
			return 0;
		endfunction

		function void note_word(logic [1:0] k, logic [15:0] a, logic [7:0] d);
			cpu_view_t e;
			e = '0;
			if (k == KIND_WRITE) put_byte(a, d);
			else if (k == KIND_EXEC) e.bad = run_instr();
			else if (k == KIND_READ) e.rdata = mem[a];
			e.pc = pc;
			e.sp = sp;
			e.acc = acc;
			e.bc = pair_get(0);
			e.de = pair_get(1);
			e.hl = pair_get(2);
			e.flags = fl;
			pending.push_back(e);
		endfunction

		function void cmp_field(string n, logic [15:0] e, logic [15:0] g);
			if (e !== g) $display("%0t: %s mismatch, expected %h, got %h", $time, n, e, g);
		endfunction

		function void check_word(cpu_view_t got);
			cpu_view_t e;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result word with nothing expected, got %h", $time, got);
				return;
			end
			e = pending.pop_front();
			if (e !== got) begin
				errors++;
				cmp_field("read_data", e.rdata, got.rdata);
				cmp_field("prog_counter", e.pc, got.pc);
				cmp_field("stack_ptr", e.sp, got.sp);
				cmp_field("accum", e.acc, got.acc);
				cmp_field("pair_bc", e.bc, got.bc);
				cmp_field("pair_de", e.de, got.de);
				cmp_field("pair_hl", e.hl, got.hl);
				cmp_field("flag_bits", e.flags, got.flags);
				cmp_field("bad_opcode", e.bad, got.bad);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  kind;
	logic [15:0] address;
	logic [7:0]  data;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  read_data;
	logic [15:0] prog_counter;
	logic [15:0] stack_ptr;
	logic [7:0]  accum;
	logic [15:0] pair_bc;
	logic [15:0] pair_de;
	logic [15:0] pair_hl;
	logic [3:0]  flag_bits;
	logic        bad_opcode;

	exec_scoreboard sb = new();
	int             words_sent = 0;
	int             send_idle_pct = 0;
	int             stall_pct = 0;
	int             hold_cycles = 0;
	logic [15:0]    written_list [$];

	cpu8080_instruction_execute_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.address(address),
		.data(data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.prog_counter(prog_counter),
		.stack_ptr(stack_ptr),
		.accum(accum),
		.pair_bc(pair_bc),
		.pair_de(pair_de),
		.pair_hl(pair_hl),
		.flag_bits(flag_bits),
		.bad_opcode(bad_opcode)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("** cpu8080_instruction_execute_core: FAILED **");
		$finish;
	end

	initial begin
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_word({read_data, prog_counter, stack_ptr, accum, pair_bc, pair_de,
				pair_hl, flag_bits, bad_opcode});
	end

	task automatic send_word(logic [1:0] k, logic [15:0] a, logic [7:0] d);
		int gap;
		in_valid <= 1'b1;
		kind <= k;
		address <= a;
		data <= d;
		do @(posedge clk); while (in_stall);
		sb.note_word(k, a, d);
		words_sent++;
		if (k == KIND_WRITE) written_list.push_back(a);
		gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task automatic make_known(logic [15:0] a);
		if (!sb.written[a]) send_word(KIND_WRITE, a, 8'($urandom));
	endtask

	// Lays down the opcode and its two following bytes at PC, makes sure every
	// byte the instruction will read holds a value, then runs it.
	task automatic step_program(int force_op, int force_imm);
		logic [15:0] pc, hl, imm, a;
		logic [7:0]  op, v;
		pc = sb.pc;
		if (force_op >= 0) begin
			send_word(KIND_WRITE, pc, force_op[7:0]);
		end else if (!sb.written[pc] || $urandom_range(99) < 70) begin
			v = ($urandom_range(99) < 85) ? 8'($urandom_range(0, OP_LAST_IMPL))
				: 8'($urandom_range(OP_LAST_IMPL + 1, 255));
			send_word(KIND_WRITE, pc, v);
		end
		for (int i = 1; i <= 2; i++) begin
			a = pc + 16'(i);
			if (force_imm >= 0) send_word(KIND_WRITE, a, (i == 1) ? force_imm[7:0] : force_imm[15:8]);
			else if (!sb.written[a] || $urandom_range(99) < 70)
				send_word(KIND_WRITE, a, 8'($urandom));
		end
		op = sb.mem[pc];
		imm = {sb.mem[pc + 16'd2], sb.mem[pc + 16'd1]};
		hl = sb.pair_get(2);
		if (op <= OP_LAST_IMPL) begin
			if (op >= 8'h40) begin
				if (op[2:0] == 3'd6 && op != OP_HLT) make_known(hl);
			end else if (op[2:0] == 3'd2 && op[3]) begin
				if (op[5:4] < 2) make_known(sb.pair_get(op[5:4]));
				else begin
					make_known(imm);
					if (op[5:4] == 2) make_known(imm + 16'd1);
				end
			end else if ((op[2:0] == 3'd4 || op[2:0] == 3'd5) && op[5:3] == 3'd6) begin
				make_known(hl);
			end
		end
		send_word(KIND_EXEC, 16'($urandom), 8'($urandom));
	endtask

	task automatic random_word();
		int r;
		r = $urandom_range(99);
		if (r < 70) step_program(-1, -1);
		else if (r < 80) send_word(KIND_READ,
			written_list[$urandom_range(written_list.size() - 1)], 8'($urandom));
		else if (r < 95) send_word(KIND_WRITE, 16'($urandom), 8'($urandom));
		else send_word(KIND_NONE, 16'($urandom), 8'($urandom));
	endtask

	initial begin
		logic [7:0] directed_ops [$];
		in_valid = 0;
		kind = KIND_NONE;
		address = 0;
		data = 0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(KIND_NONE, 16'hffff, 8'hff);
		send_word(KIND_WRITE, 16'hffff, 8'h00);
		send_word(KIND_READ, 16'hffff, 8'h00);
		step_program(8'h21, 16'hffff);
		step_program(8'h22, 16'hffff);
		step_program(8'h2a, 16'hffff);
		directed_ops = '{8'h00, 8'h01, 8'h31, 8'h0a, 8'h02, 8'h34, 8'h35, 8'h36, 8'h07,
			8'h1f, 8'h27, 8'h2f, 8'h37, 8'h3f, 8'h29, 8'h76, 8'h7e, 8'h86, 8'h8f,
			8'h90, 8'hff, 8'h08, 8'h20, 8'h30};
		foreach (directed_ops[i]) step_program(directed_ops[i], -1);
		drain_results();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 50 : (ph == 3) ? 38 : 0;
			stall_pct = (ph == 2) ? 50 : (ph == 3) ? 38 : 0;
			if (ph == 0) hold_cycles = 400;
			while (words_sent < ITEM_COUNT * (ph + 1) / 4) random_word();
			drain_results();
		end

		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("** cpu8080_instruction_execute_core: PASSED **");
		end else begin
			$display("** cpu8080_instruction_execute_core: FAILED **");
		end
		$finish;
	end

endmodule
